>>> hw/rtl/crps_pkg.sv
package crps_pkg;

  // Coordinate and step-count widths.
  localparam int COORD_BITS = 24;
  localparam int MAX_DIV    = 31;
  localparam int DIV_W      = 5;
  localparam int DIV_RESET  = 16;

  // Derived datapath widths.
  localparam int CW = COORD_BITS;
  localparam int AW = CW + 4;              // cubic and square coefficients
  localparam int MW = 3 * DIV_W;           // monomials j^3, j^2*n, j*n^2, n^3
  localparam int PW = AW + MW + 1;         // one coefficient times one monomial
  localparam int NW = PW + 3;              // rounded numerator 2*num + den
  localparam int QB = 2 * ((CW + 7) / 2);  // quotient bits, two per divider cycle
  localparam int DW = MW + 1;              // divisor 2*den
  localparam int RW = DW + 1;              // partial remainder

  // Command queue between the front and the back.
  localparam int FIFO_DEPTH = 4;
  localparam int FIFO_AW    = 2;

  typedef logic signed [CW-1:0] coord_t;
  typedef logic signed [AW-1:0] coef_t;

  // One command: either a curve segment (per-lane polynomial) or a point echo.
  typedef struct packed {
    logic             is_point;
    logic [DIV_W-1:0] n;
    coef_t  [2:0]     a;
    coef_t  [2:0]     b;
    coord_t [2:0]     v0;
    coord_t [2:0]     p1;
  } cmd_t;

  localparam logic signed [QB+1:0] SAT_HI = (QB + 2)'((2 ** (CW - 1)) - 1);
  localparam logic signed [QB+1:0] SAT_LO = -SAT_HI - 1;

  // Clamp a wide signed value to the coordinate range.
  function automatic coord_t sat_wide(input logic signed [QB+1:0] x);
    coord_t r;
    if (x > SAT_HI) begin
      r = SAT_HI[CW-1:0];
    end else if (x < SAT_LO) begin
      r = SAT_LO[CW-1:0];
    end else begin
      r = x[CW-1:0];
    end
    return r;
  endfunction

endpackage

>>> hw/rtl/catmull_rom_point_stream.sv
// Catmull-Rom point stream.
// Input channel (in_valid / in_stall): one control word per accepted item, signed
// Q15.8 coordinates in_x, in_y, in_z and in_last on the final point of a path.
// Output channel (out_valid / out_stall): curve words, div_num per segment, and
// after the final point of a path that point again with out_last set.
// Configuration: an APB-style port; div_num lives at byte address 0 (reset 16).
// Program it only while the stream is idle.
// Flow: the front takes a new control word only after it has queued the last
// one's commands and updated its window, and queues up to four commands. Each
// curve word passes through the back end's monomials, products, sum and a
// two-bit-per-cycle divider by 2*div_num^3 before it is handed off.
// Reset (rst_n low at a clock edge) empties the queue, drops the output word and
// starts a new path. When the receiver stalls, the output word holds and the back
// end waits with its next word; the front keeps taking items until the queue fills.
module catmull_rom_point_stream (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  logic signed [23:0]    in_x,
  input  logic signed [23:0]    in_y,
  input  logic signed [23:0]    in_z,
  input  logic                  in_last,
  output logic                  out_valid,
  input  logic                  out_stall,
  output logic signed [23:0]    out_x,
  output logic signed [23:0]    out_y,
  output logic signed [23:0]    out_z,
  output logic                  out_last,
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [2:0]            paddr,
  input  logic [31:0]           pwdata,
  output logic [31:0]           prdata,
  output logic                  pready
);

  localparam logic ADDR_DIV_NUM = 1'b0;

  logic [crps_pkg::DIV_W-1:0] div_r;
  logic [crps_pkg::DIV_W-1:0] div_n;
  crps_pkg::cmd_t             f_cmd;
  crps_pkg::cmd_t             b_cmd;
  logic                       push;
  logic                       pop;
  logic                       full;
  logic                       empty;
  logic                       wr_en;

  // Register access.
  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite && (paddr[2] == ADDR_DIV_NUM);
  assign prdata = (paddr[2] == ADDR_DIV_NUM) ? {{(32 - crps_pkg::DIV_W){1'b0}}, div_r} : '0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      div_r <= crps_pkg::DIV_W'(crps_pkg::DIV_RESET);
    end else if (wr_en) begin
      div_r <= pwdata[crps_pkg::DIV_W-1:0];
    end
  end

  // Step count as used: zero counts as one, capped at the maximum.
  always_comb begin
    if (div_r == '0) begin
      div_n = crps_pkg::DIV_W'(1);
    end else if (div_r > crps_pkg::DIV_W'(crps_pkg::MAX_DIV)) begin
      div_n = crps_pkg::DIV_W'(crps_pkg::MAX_DIV);
    end else begin
      div_n = div_r;
    end
  end

  crps_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_x     (in_x),
    .in_y     (in_y),
    .in_z     (in_z),
    .in_last  (in_last),
    .div_n    (div_n),
    .cmd_o    (f_cmd),
    .cmd_push (push),
    .cmd_full (full)
  );

  crps_fifo u_fifo (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (push),
    .din   (f_cmd),
    .pop   (pop),
    .dout  (b_cmd),
    .full  (full),
    .empty (empty)
  );

  crps_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd_i     (b_cmd),
    .cmd_empty (empty),
    .cmd_pop   (pop),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_x     (out_x),
    .out_y     (out_y),
    .out_z     (out_z),
    .out_last  (out_last)
  );

endmodule

>>> hw/rtl/crps_fifo.sv
module crps_fifo (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            push,
  input  crps_pkg::cmd_t  din,
  input  logic            pop,
  output crps_pkg::cmd_t  dout,
  output logic            full,
  output logic            empty
);

  crps_pkg::cmd_t                    mem_r [crps_pkg::FIFO_DEPTH];
  logic [crps_pkg::FIFO_AW-1:0]      wp_r;
  logic [crps_pkg::FIFO_AW-1:0]      rp_r;
  logic [crps_pkg::FIFO_AW:0]        cnt_r;

  assign full  = (cnt_r == (crps_pkg::FIFO_AW + 1)'(crps_pkg::FIFO_DEPTH));
  assign empty = (cnt_r == '0);
  assign dout  = mem_r[rp_r];

  // Storage holds payload only.
  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wp_r] <= din;
    end
  end

  // Pointers and fill count.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      if (push) begin
        wp_r <= wp_r + 1'b1;
      end
      if (pop) begin
        rp_r <= rp_r + 1'b1;
      end
      if (push && !pop) begin
        cnt_r <= cnt_r + 1'b1;
      end else if (pop && !push) begin
        cnt_r <= cnt_r - 1'b1;
      end
    end
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n) !(push && full))
    else $error("command queue written while full");
  a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n) !(pop && empty))
    else $error("command queue read while empty");

endmodule

>>> hw/rtl/crps_front.sv
module crps_front (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  crps_pkg::coord_t              in_x,
  input  crps_pkg::coord_t              in_y,
  input  crps_pkg::coord_t              in_z,
  input  logic                          in_last,
  input  logic [crps_pkg::DIV_W-1:0]    div_n,
  output crps_pkg::cmd_t                cmd_o,
  output logic                          cmd_push,
  input  logic                          cmd_full
);

  localparam logic [2:0] F_IDLE = 3'd0;
  localparam logic [2:0] F_SEGA = 3'd1;
  localparam logic [2:0] F_SEGB = 3'd2;
  localparam logic [2:0] F_SEGC = 3'd3;
  localparam logic [2:0] F_PT   = 3'd4;
  localparam logic [2:0] F_UPD  = 3'd5;

  localparam int CW = crps_pkg::CW;
  localparam int AW = crps_pkg::AW;

  logic [2:0]        st_r;
  crps_pkg::coord_t  w_r  [3][3];
  crps_pkg::coord_t  sg_r [3];
  crps_pkg::coord_t  p_r  [3];
  crps_pkg::coord_t  s_r  [3];
  crps_pkg::coord_t  e_r  [3];
  logic              last_r;
  logic [1:0]        cnt_r;

  crps_pkg::coord_t  in_p [3];
  crps_pkg::coord_t  q0 [3];
  crps_pkg::coord_t  q1 [3];
  crps_pkg::coord_t  q2 [3];
  crps_pkg::coord_t  q3 [3];
  logic              accept;

  // End-point extrapolation: end + floor((end - nb) / 2), saturated.
  function automatic crps_pkg::coord_t ghost(input crps_pkg::coord_t e,
                                             input crps_pkg::coord_t nb);
    logic signed [CW:0]   d;
    logic signed [CW:0]   s;
    logic signed [crps_pkg::QB+1:0] w;
    d = {e[CW-1], e} - {nb[CW-1], nb};
    s = {e[CW-1], e} + {d[CW], d[CW:1]};
    w = s;
    return crps_pkg::sat_wide(w);
  endfunction

  assign in_p[0] = in_x;
  assign in_p[1] = in_y;
  assign in_p[2] = in_z;

  assign accept   = in_valid && (st_r == F_IDLE);
  assign in_stall = (st_r != F_IDLE);
  assign cmd_push = ((st_r == F_SEGA) || (st_r == F_SEGB) || (st_r == F_SEGC) ||
                     (st_r == F_PT)) && !cmd_full;

  // Pick the four points of the segment that this state emits.
  always_comb begin
    for (int c = 0; c < 3; c++) begin
      case (st_r)
        F_SEGA: begin
          q0[c] = (cnt_r == 2'd2) ? sg_r[c] : w_r[0][c];
          q1[c] = w_r[1][c];
          q2[c] = w_r[2][c];
          q3[c] = p_r[c];
        end
        F_SEGB: begin
          q0[c] = w_r[1][c];
          q1[c] = w_r[2][c];
          q2[c] = p_r[c];
          q3[c] = e_r[c];
        end
        default: begin
          q0[c] = s_r[c];
          q1[c] = w_r[2][c];
          q2[c] = p_r[c];
          q3[c] = e_r[c];
        end
      endcase
    end
  end

  // Tangents and polynomial coefficients for each lane.
  always_comb begin
    logic signed [CW:0]   d0;
    logic signed [CW:0]   d1;
    logic signed [AW-1:0] e1;
    logic signed [AW-1:0] e2;
    logic signed [AW-1:0] ev0;
    logic signed [AW-1:0] ev1;
    logic signed [AW-1:0] dd;
    cmd_o.is_point = (st_r == F_PT);
    cmd_o.n        = div_n;
    for (int c = 0; c < 3; c++) begin
      d0  = {q2[c][CW-1], q2[c]} - {q0[c][CW-1], q0[c]};
      d1  = {q3[c][CW-1], q3[c]} - {q1[c][CW-1], q1[c]};
      cmd_o.v0[c] = d0[CW:1];
      ev0 = $signed(d0[CW:1]);
      ev1 = $signed(d1[CW:1]);
      e1  = q1[c];
      e2  = q2[c];
      dd  = e2 - e1;
      cmd_o.a[c]  = (e1 <<< 1) - (e2 <<< 1) + ev0 + ev1;
      cmd_o.b[c]  = (dd <<< 1) + dd - (ev0 <<< 1) - ev1;
      cmd_o.p1[c] = (st_r == F_PT) ? p_r[c] : q1[c];
    end
  end

  // Sequencer: capture a point, queue its commands, then update the window.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r  <= F_IDLE;
      cnt_r <= '0;
      for (int k = 0; k < 3; k++) begin
        sg_r[k] <= '0;
        for (int c = 0; c < 3; c++) begin
          w_r[k][c] <= '0;
        end
      end
    end else begin
      case (st_r)
        F_IDLE: begin
          if (accept) begin
            for (int c = 0; c < 3; c++) begin
              p_r[c] <= in_p[c];
              s_r[c] <= ghost(w_r[2][c], in_p[c]);
              e_r[c] <= ghost(in_p[c], w_r[2][c]);
            end
            last_r <= in_last;
            if (cnt_r == 2'd0) begin
              st_r <= in_last ? F_PT : F_UPD;
            end else if (cnt_r == 2'd1) begin
              st_r <= in_last ? F_SEGC : F_UPD;
            end else begin
              st_r <= F_SEGA;
            end
          end
        end
        F_SEGA: begin
          if (!cmd_full) begin
            st_r <= last_r ? F_SEGB : F_UPD;
          end
        end
        F_SEGB, F_SEGC: begin
          if (!cmd_full) begin
            st_r <= F_PT;
          end
        end
        F_PT: begin
          if (!cmd_full) begin
            st_r <= F_UPD;
          end
        end
        F_UPD: begin
          if (last_r) begin
            cnt_r <= '0;
            for (int k = 0; k < 3; k++) begin
              sg_r[k] <= '0;
              for (int c = 0; c < 3; c++) begin
                w_r[k][c] <= '0;
              end
            end
          end else begin
            if (cnt_r == 2'd1) begin
              for (int c = 0; c < 3; c++) begin
                sg_r[c] <= s_r[c];
              end
            end
            for (int c = 0; c < 3; c++) begin
              w_r[0][c] <= w_r[1][c];
              w_r[1][c] <= w_r[2][c];
              w_r[2][c] <= p_r[c];
            end
            if (cnt_r != 2'd3) begin
              cnt_r <= cnt_r + 2'd1;
            end
          end
          st_r <= F_IDLE;
        end
        default: begin
          st_r <= F_IDLE;
        end
      endcase
    end
  end

endmodule

>>> hw/rtl/crps_back.sv
module crps_back (
  input  logic              clk,
  input  logic              rst_n,
  input  crps_pkg::cmd_t    cmd_i,
  input  logic              cmd_empty,
  output logic              cmd_pop,
  output logic              out_valid,
  input  logic              out_stall,
  output crps_pkg::coord_t  out_x,
  output crps_pkg::coord_t  out_y,
  output crps_pkg::coord_t  out_z,
  output logic              out_last
);

  localparam logic [2:0] B_IDLE  = 3'd0;
  localparam logic [2:0] B_MONO1 = 3'd1;
  localparam logic [2:0] B_MONO2 = 3'd2;
  localparam logic [2:0] B_MUL   = 3'd3;
  localparam logic [2:0] B_SUM   = 3'd4;
  localparam logic [2:0] B_ABS   = 3'd5;
  localparam logic [2:0] B_DIV   = 3'd6;
  localparam logic [2:0] B_WAIT  = 3'd7;

  localparam int DIV_W = crps_pkg::DIV_W;
  localparam int MW    = crps_pkg::MW;
  localparam int PW    = crps_pkg::PW;
  localparam int NW    = crps_pkg::NW;
  localparam int QB    = crps_pkg::QB;
  localparam int DW    = crps_pkg::DW;
  localparam int RW    = crps_pkg::RW;
  localparam int STEPS = QB / 2;
  localparam int DC_W  = $clog2(STEPS);

  logic [2:0]                st_r;
  crps_pkg::cmd_t            cmd_r;
  logic [DIV_W-1:0]          j_r;
  logic [2*DIV_W-1:0]        jj_r;
  logic [2*DIV_W-1:0]        nn_r;
  logic [MW-1:0]             j3_r;
  logic [MW-1:0]             j2n_r;
  logic [MW-1:0]             jn2_r;
  logic [MW-1:0]             n3_r;
  logic signed [PW-1:0]      pa_r [3];
  logic signed [PW-1:0]      pb_r [3];
  logic signed [PW-1:0]      pv_r [3];
  logic signed [PW-1:0]      pp_r [3];
  logic signed [PW+1:0]      sum_r [3];
  logic                      neg_r [3];
  logic [RW-1:0]             rem_r [3];
  logic [QB-1:0]             sh_r  [3];
  logic [QB-1:0]             q_r   [3];
  logic [DC_W-1:0]           dcnt_r;

  logic [RW-1:0]             rem_nxt [3];
  logic [QB-1:0]             sh_nxt  [3];
  logic [QB-1:0]             q_nxt   [3];
  logic [NW-1:0]             un      [3];
  logic                      nneg    [3];
  crps_pkg::coord_t          res     [3];
  logic [DW-1:0]             dvs;

  logic                      out_valid_r;
  crps_pkg::coord_t          out_x_r;
  crps_pkg::coord_t          out_y_r;
  crps_pkg::coord_t          out_z_r;
  logic                      out_last_r;
  logic                      out_free;
  logic                      load;
  logic                      seg_done;

  assign cmd_pop   = (st_r == B_IDLE) && !cmd_empty;
  assign out_free  = !out_valid_r || !out_stall;
  assign load      = (st_r == B_WAIT) && out_free;
  assign seg_done  = cmd_r.is_point || (j_r == cmd_r.n - 1'b1);
  assign dvs       = {n3_r, 1'b0};

  assign out_valid = out_valid_r;
  assign out_x     = out_x_r;
  assign out_y     = out_y_r;
  assign out_z     = out_z_r;
  assign out_last  = out_last_r;

  // Rounded numerator 2*num + den, split into sign and magnitude.
  always_comb begin
    logic signed [NW-1:0] nv;
    for (int c = 0; c < 3; c++) begin
      nv      = $signed({sum_r[c], 1'b0}) + $signed({{(NW - MW){1'b0}}, n3_r});
      nneg[c] = nv[NW-1];
      un[c]   = nv[NW-1] ? NW'(-nv) : NW'(nv);
    end
  end

  // Two restoring division steps per cycle in each lane.
  always_comb begin
    logic [RW-1:0] rm;
    logic [QB-1:0] sh;
    logic [QB-1:0] q;
    for (int c = 0; c < 3; c++) begin
      rm = rem_r[c];
      sh = sh_r[c];
      q  = q_r[c];
      for (int k = 0; k < 2; k++) begin
        rm = {rm[RW-2:0], sh[QB-1]};
        sh = {sh[QB-2:0], 1'b0};
        if (rm >= {1'b0, dvs}) begin
          rm = rm - {1'b0, dvs};
          q  = {q[QB-2:0], 1'b1};
        end else begin
          q  = {q[QB-2:0], 1'b0};
        end
      end
      rem_nxt[c] = rm;
      sh_nxt[c]  = sh;
      q_nxt[c]   = q;
    end
  end

  // Floor quotient from magnitude, then saturate.
  always_comb begin
    logic signed [QB+1:0] qm;
    logic signed [QB+1:0] rnd;
    for (int c = 0; c < 3; c++) begin
      qm  = $signed({2'b00, q_r[c]});
      rnd = $signed({{(QB + 1){1'b0}}, (rem_r[c] != '0)});
      res[c] = cmd_r.is_point ? cmd_r.p1[c]
                              : crps_pkg::sat_wide(neg_r[c] ? -(qm + rnd) : qm);
    end
  end

  // Evaluation sequencer: monomials, products, sum, sign split, divide, hand off; point echoes go straight to hand-off.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r   <= B_IDLE;
      j_r    <= '0;
      dcnt_r <= '0;
    end else begin
      case (st_r)
        B_IDLE: begin
          if (!cmd_empty) begin
            cmd_r <= cmd_i;
            j_r   <= '0;
            st_r  <= cmd_i.is_point ? B_WAIT : B_MONO1;
          end
        end
        B_MONO1: begin
          jj_r <= (2 * DIV_W)'(j_r) * (2 * DIV_W)'(j_r);
          nn_r <= (2 * DIV_W)'(cmd_r.n) * (2 * DIV_W)'(cmd_r.n);
          st_r <= B_MONO2;
        end
        B_MONO2: begin
          j3_r  <= MW'(jj_r) * MW'(j_r);
          j2n_r <= MW'(jj_r) * MW'(cmd_r.n);
          jn2_r <= MW'(nn_r) * MW'(j_r);
          n3_r  <= MW'(nn_r) * MW'(cmd_r.n);
          st_r  <= B_MUL;
        end
        B_MUL: begin
          for (int c = 0; c < 3; c++) begin
            pa_r[c] <= $signed(cmd_r.a[c])  * $signed({1'b0, j3_r});
            pb_r[c] <= $signed(cmd_r.b[c])  * $signed({1'b0, j2n_r});
            pv_r[c] <= $signed(cmd_r.v0[c]) * $signed({1'b0, jn2_r});
            pp_r[c] <= $signed(cmd_r.p1[c]) * $signed({1'b0, n3_r});
          end
          st_r <= B_SUM;
        end
        B_SUM: begin
          for (int c = 0; c < 3; c++) begin
            sum_r[c] <= (PW + 2)'(pa_r[c]) + (PW + 2)'(pb_r[c]) +
                        (PW + 2)'(pv_r[c]) + (PW + 2)'(pp_r[c]);
          end
          st_r <= B_ABS;
        end
        B_ABS: begin
          for (int c = 0; c < 3; c++) begin
            neg_r[c] <= nneg[c];
            rem_r[c] <= un[c][QB+RW-1:QB];
            sh_r[c]  <= un[c][QB-1:0];
            q_r[c]   <= '0;
          end
          dcnt_r <= '0;
          st_r   <= B_DIV;
        end
        B_DIV: begin
          for (int c = 0; c < 3; c++) begin
            rem_r[c] <= rem_nxt[c];
            sh_r[c]  <= sh_nxt[c];
            q_r[c]   <= q_nxt[c];
          end
          dcnt_r <= dcnt_r + 1'b1;
          if (dcnt_r == DC_W'(STEPS - 1)) begin
            st_r <= B_WAIT;
          end
        end
        B_WAIT: begin
          if (out_free) begin
            if (seg_done) begin
              st_r <= B_IDLE;
            end else begin
              j_r  <= j_r + 1'b1;
              st_r <= B_MONO1;
            end
          end
        end
        default: begin
          st_r <= B_IDLE;
        end
      endcase
    end
  end

  // Output register: holds a word until the receiver takes it.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (load) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      out_x_r    <= res[0];
      out_y_r    <= res[1];
      out_z_r    <= res[2];
      out_last_r <= cmd_r.is_point;
    end
  end

  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
      (out_valid_r && out_stall) |=> $stable(out_x_r) && $stable(out_last_r))
    else $error("stalled output word overwritten");
  a_step_in_range: assert property (@(posedge clk) disable iff (!rst_n)
      (st_r == B_DIV) |-> (j_r < cmd_r.n))
    else $error("curve step beyond segment length");
  a_last_only_echo: assert property (@(posedge clk) disable iff (!rst_n)
      (load && !cmd_r.is_point) |=> !out_last_r)
    else $error("last flag set on a curve point");

endmodule
